// ===== rtl/core/ppc_integer_add_or_unit_defines.svh =====
// Assertion helpers for the integer add/or unit.
// Both forms sample on the rising clock edge and stand down while reset is low.
`ifndef PPC_INTEGER_ADD_OR_UNIT_DEFINES_SVH
`define PPC_INTEGER_ADD_OR_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define PPCALU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ppcalu check failed");
// Next-cycle implication.
`define PPCALU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ppcalu check failed");
`else
`define PPCALU_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PPCALU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/ppcalu_pkg.sv =====
package ppcalu_pkg;

    localparam int IDX_W  = 5;
    localparam int DATA_W = 32;
    localparam int IMM_W  = 16;
    localparam int CR_W   = 4;

    typedef enum logic [1:0] {
        OP_ADDI  = 2'd0,
        OP_ADDIS = 2'd1,
        OP_ADD   = 2'd2,
        OP_ORI   = 2'd3
    } t_op;

    // CR0 field encodings
    localparam logic [CR_W-1:0] CR_NEG  = 4'h1;
    localparam logic [CR_W-1:0] CR_POS  = 4'h2;
    localparam logic [CR_W-1:0] CR_ZERO = 4'h4;
    localparam logic [CR_W-1:0] CR_SO   = 4'h8;

    typedef struct packed {
        t_op              operation;
        logic [IDX_W-1:0] target_reg;
        logic [IDX_W-1:0] source_a_reg;
        logic [IDX_W-1:0] source_b_reg;
        logic [IMM_W-1:0] immediate;
        logic             record_overflow;
        logic             record_cr0;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]  dest_reg;
        logic [DATA_W-1:0] written_value;
        logic [CR_W-1:0]   cr0_field;
        logic              overflow_flag;
        logic              summary_overflow;
    } t_rsp;

    // architected condition state
    typedef struct packed {
        logic [CR_W-1:0] cr0;
        logic            ov;
        logic            so;
    } t_flags;

    // register file write port
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } t_wr;

endpackage

// ===== rtl/core/ppcalu_req_if.sv =====
interface ppcalu_req_if;
    logic               valid;
    logic               ready;
    ppcalu_pkg::t_req   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ppcalu_rsp_if.sv =====
interface ppcalu_rsp_if;
    logic               valid;
    logic               ready;
    ppcalu_pkg::t_rsp   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ppcalu_regfile.sv =====
module ppcalu_regfile #(
    parameter int REG_COUNT = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rd_en,
    input  logic [ppcalu_pkg::IDX_W-1:0]        i_rd_addr_a,
    input  logic [ppcalu_pkg::IDX_W-1:0]        i_rd_addr_b,
    input  ppcalu_pkg::t_wr                     i_wr,
    output logic [ppcalu_pkg::DATA_W-1:0]       o_rd_data_a,
    output logic [ppcalu_pkg::DATA_W-1:0]       o_rd_data_b
);

    localparam int AW = $clog2(REG_COUNT);
    localparam logic [ppcalu_pkg::IDX_W:0] DEPTH = (ppcalu_pkg::IDX_W + 1)'(REG_COUNT);

    logic [ppcalu_pkg::DATA_W-1:0] r_mem [REG_COUNT];
    logic [REG_COUNT-1:0]          r_vld;
    logic [ppcalu_pkg::DATA_W-1:0] r_data_a;
    logic [ppcalu_pkg::DATA_W-1:0] r_data_b;
    logic [ppcalu_pkg::DATA_W-1:0] r_fwd_value;
    logic                          r_hit_a;
    logic                          r_hit_b;
    logic                          r_fwd_a;
    logic                          r_fwd_b;

    logic s_a_in;
    logic s_b_in;
    logic s_wr_in;
    logic s_wr_do;

    // indices beyond the file read as zero and drop writes
    assign s_a_in  = {1'b0, i_rd_addr_a} < DEPTH;
    assign s_b_in  = {1'b0, i_rd_addr_b} < DEPTH;
    assign s_wr_in = {1'b0, i_wr.idx} < DEPTH;
    assign s_wr_do = i_wr.en && s_wr_in;

    // storage: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (s_wr_do) begin
            r_mem[i_wr.idx[AW-1:0]] <= i_wr.value;
        end
        if (i_rd_en) begin
            if (s_a_in) begin
                r_data_a <= r_mem[i_rd_addr_a[AW-1:0]];
            end
            if (s_b_in) begin
                r_data_b <= r_mem[i_rd_addr_b[AW-1:0]];
            end
            r_fwd_value <= i_wr.value;
        end
    end

    // valid bits stand in for the zero reset of the storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
        end else begin
            if (s_wr_do) begin
                r_vld[i_wr.idx[AW-1:0]] <= 1'b1;
            end
            if (i_rd_en) begin
                r_hit_a <= s_a_in && r_vld[i_rd_addr_a[AW-1:0]];
                r_hit_b <= s_b_in && r_vld[i_rd_addr_b[AW-1:0]];
                // catch a write landing on the same edge as the read
                r_fwd_a <= s_wr_do && (i_wr.idx == i_rd_addr_a);
                r_fwd_b <= s_wr_do && (i_wr.idx == i_rd_addr_b);
            end
        end
    end

    // select forwarded, stored or zero
    assign o_rd_data_a = r_fwd_a ? r_fwd_value : (r_hit_a ? r_data_a : '0);
    assign o_rd_data_b = r_fwd_b ? r_fwd_value : (r_hit_b ? r_data_b : '0);

endmodule

// ===== rtl/core/ppcalu_exec.sv =====
module ppcalu_exec (
    input  ppcalu_pkg::t_req                   i_req,
    input  logic [ppcalu_pkg::DATA_W-1:0]      i_opnd_a,
    input  logic [ppcalu_pkg::DATA_W-1:0]      i_opnd_b,
    input  ppcalu_pkg::t_flags                 i_flags,
    output ppcalu_pkg::t_rsp                   o_rsp,
    output ppcalu_pkg::t_flags                 o_flags
);

    logic [ppcalu_pkg::DATA_W-1:0] s_base;
    logic [ppcalu_pkg::DATA_W-1:0] s_addend;
    logic [ppcalu_pkg::DATA_W-1:0] s_sum;
    logic [ppcalu_pkg::DATA_W-1:0] s_value;
    logic [ppcalu_pkg::IDX_W-1:0]  s_dest;
    logic                          s_ovf;
    ppcalu_pkg::t_flags            s_flags;

    // base: register A, or zero for the immediate forms with A of zero
    always_comb begin
        s_base = i_opnd_a;
        if ((i_req.operation == ppcalu_pkg::OP_ADDI ||
             i_req.operation == ppcalu_pkg::OP_ADDIS) &&
            i_req.source_a_reg == '0) begin
            s_base = '0;
        end
    end

    // second operand
    always_comb begin
        case (i_req.operation)
            ppcalu_pkg::OP_ADDI: begin
                s_addend = {{(ppcalu_pkg::DATA_W - ppcalu_pkg::IMM_W){i_req.immediate[15]}},
                            i_req.immediate};
            end
            ppcalu_pkg::OP_ADDIS: begin
                s_addend = {i_req.immediate, {ppcalu_pkg::IMM_W{1'b0}}};
            end
            default: begin
                s_addend = i_opnd_b;
            end
        endcase
    end

    assign s_sum = s_base + s_addend;
    // same-sign operands giving a result of the other sign
    assign s_ovf = ~(i_opnd_a[31] ^ i_opnd_b[31]) & (i_opnd_a[31] ^ s_sum[31]);

    // result and condition update
    always_comb begin
        s_flags = i_flags;
        s_value = s_sum;
        s_dest  = i_req.target_reg;
        case (i_req.operation)
            ppcalu_pkg::OP_ADD: begin
                if (i_req.record_overflow) begin
                    s_flags.ov = s_ovf;
                    s_flags.so = i_flags.so | s_ovf;
                end
                if (i_req.record_cr0) begin
                    if (s_sum[31]) begin
                        s_flags.cr0 = ppcalu_pkg::CR_NEG;
                    end else if (s_sum != '0) begin
                        s_flags.cr0 = ppcalu_pkg::CR_POS;
                    end else begin
                        s_flags.cr0 = ppcalu_pkg::CR_ZERO;
                    end
                    if (s_flags.so) begin
                        s_flags.cr0 = s_flags.cr0 | ppcalu_pkg::CR_SO;
                    end
                end
            end
            ppcalu_pkg::OP_ORI: begin
                s_value = i_opnd_a | {{(ppcalu_pkg::DATA_W - ppcalu_pkg::IMM_W){1'b0}},
                                      i_req.immediate};
                s_dest  = i_req.source_a_reg;
            end
            default: begin
                s_value = s_sum;
            end
        endcase
    end

    assign o_flags                = s_flags;
    assign o_rsp.dest_reg         = s_dest;
    assign o_rsp.written_value    = s_value;
    assign o_rsp.cr0_field        = s_flags.cr0;
    assign o_rsp.overflow_flag    = s_flags.ov;
    assign o_rsp.summary_overflow = s_flags.so;

endmodule

// ===== rtl/core/ppc_integer_add_or_unit.sv =====
// Integer add/or execute unit with its own general register file.
//
// i_req carries one decoded instruction (addi, addis, add, ori) per request;
// o_rsp returns one result per request: the register written, the value,
// and the CR0, XER OV and XER SO state after the instruction.
// Both channels move a request when valid and ready are high at a clock edge.
//
// Path: an accepted instruction is held in the operand stage, then in the result
// register, which drives o_rsp.valid. Operands are read from the register file at the accepting
// edge; the add/or logic then sits between the operand and result registers.
// Throughput: one instruction per cycle while o_rsp.ready is high. A value
// written by one instruction is forwarded to the one accepted on the same edge,
// so dependent instructions issue back to back.
// Reset: all registers read as zero (per-register valid bits, cleared at once),
// CR0, OV and SO clear, both stages empty. No clearing pass is needed.
// Receiver stall: the result register holds; one more instruction may wait in
// the operand stage, after which i_req.ready falls until o_rsp.ready returns.
`include "ppc_integer_add_or_unit_defines.svh"

module ppc_integer_add_or_unit #(
    parameter int REG_COUNT = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ppcalu_req_if.sink    i_req,
    ppcalu_rsp_if.source  o_rsp
);

    logic                 r_s1_valid;
    logic                 n_s1_valid;
    ppcalu_pkg::t_req     r_s1_req;
    logic                 r_out_valid;
    logic                 n_out_valid;
    ppcalu_pkg::t_rsp     r_out_rsp;
    ppcalu_pkg::t_flags   r_flags;
    ppcalu_pkg::t_flags   n_flags;

    logic                              s_out_free;
    logic                              s_s1_adv;
    logic                              s_accept;
    logic [ppcalu_pkg::IDX_W-1:0]      s_rd_addr_a;
    logic [ppcalu_pkg::DATA_W-1:0]     s_opnd_a;
    logic [ppcalu_pkg::DATA_W-1:0]     s_opnd_b;
    ppcalu_pkg::t_rsp                  s_rsp;
    ppcalu_pkg::t_flags                s_flags;
    ppcalu_pkg::t_wr                   s_wr;

    // handshake
    assign s_out_free  = !r_out_valid || o_rsp.ready;
    assign s_s1_adv    = r_s1_valid && s_out_free;
    assign i_req.ready = !r_s1_valid || s_out_free;
    assign s_accept    = i_req.valid && i_req.ready;

    // ori reads its source through the D field
    assign s_rd_addr_a = (i_req.data.operation == ppcalu_pkg::OP_ORI) ?
                         i_req.data.target_reg : i_req.data.source_a_reg;

    // write back as the instruction leaves the operand stage
    assign s_wr.en    = s_s1_adv;
    assign s_wr.idx   = s_rsp.dest_reg;
    assign s_wr.value = s_rsp.written_value;

    ppcalu_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (s_accept),
        .i_rd_addr_a (s_rd_addr_a),
        .i_rd_addr_b (i_req.data.source_b_reg),
        .i_wr        (s_wr),
        .o_rd_data_a (s_opnd_a),
        .o_rd_data_b (s_opnd_b)
    );

    ppcalu_exec u_exec (
        .i_req    (r_s1_req),
        .i_opnd_a (s_opnd_a),
        .i_opnd_b (s_opnd_b),
        .i_flags  (r_flags),
        .o_rsp    (s_rsp),
        .o_flags  (s_flags)
    );

    // next control state
    always_comb begin
        n_s1_valid  = s_accept || (r_s1_valid && !s_s1_adv);
        n_out_valid = s_s1_adv || (r_out_valid && !o_rsp.ready);
        n_flags     = s_s1_adv ? s_flags : r_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_flags     <= n_flags;
        end
    end

    // hold payload until the stage advances
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_req <= i_req.data;
        end
        if (s_s1_adv) begin
            r_out_rsp <= s_rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_rsp;

    // checks
    `PPCALU_ASSERT_NEXT(a_so_sticky, i_clk, i_rst_n, r_flags.so, r_flags.so)
    `PPCALU_ASSERT_NOW(a_ov_implies_so, i_clk, i_rst_n, r_flags.ov, r_flags.so)
    `PPCALU_ASSERT_NOW(a_cr0_one_hot, i_clk, i_rst_n, 1'b1, $onehot0(r_flags.cr0[2:0]))
    `PPCALU_ASSERT_NOW(a_full_blocks_input, i_clk, i_rst_n, r_s1_valid && r_out_valid && !o_rsp.ready, !i_req.ready)

endmodule

// ===== tb/sv/tb_ppc_integer_add_or_unit.sv =====
module tb_ppc_integer_add_or_unit;

    localparam int DATA_W = ppcalu_pkg::DATA_W;
    localparam int IDX_W  = ppcalu_pkg::IDX_W;
    localparam int IMM_W  = ppcalu_pkg::IMM_W;
    localparam int CR_W   = ppcalu_pkg::CR_W;

    typedef ppcalu_pkg::t_req t_req;
    typedef ppcalu_pkg::t_rsp t_rsp;
    typedef ppcalu_pkg::t_op  t_op;

    localparam t_op OP_ADDI  = ppcalu_pkg::OP_ADDI;
    localparam t_op OP_ADDIS = ppcalu_pkg::OP_ADDIS;
    localparam t_op OP_ADD   = ppcalu_pkg::OP_ADD;
    localparam t_op OP_ORI   = ppcalu_pkg::OP_ORI;

    localparam logic [CR_W-1:0] CR_NEG  = ppcalu_pkg::CR_NEG;
    localparam logic [CR_W-1:0] CR_POS  = ppcalu_pkg::CR_POS;
    localparam logic [CR_W-1:0] CR_ZERO = ppcalu_pkg::CR_ZERO;
    localparam logic [CR_W-1:0] CR_SO   = ppcalu_pkg::CR_SO;

    localparam int REG_COUNT    = 32;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;

    ppcalu_req_if req_if ();
    ppcalu_rsp_if rsp_if ();

    ppc_integer_add_or_unit #(
        .REG_COUNT (REG_COUNT)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // shadow architected state
    logic [DATA_W-1:0] shadow_gpr [REG_COUNT];
    logic [CR_W-1:0]   shadow_cr0;
    logic              shadow_ov;
    logic              shadow_so;

    t_rsp writeback_q [$];
    int   mismatch_count = 0;
    int   burst_left     = 1;
    bit   hold_off_req   = 1'b0;

    // free-running clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [DATA_W-1:0] read_shadow(logic [IDX_W-1:0] idx);
        if (int'(idx) < REG_COUNT) begin
            return shadow_gpr[idx];
        end
        return '0;
    endfunction

    function automatic void write_shadow(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        if (int'(idx) < REG_COUNT) begin
            shadow_gpr[idx] = value;
        end
    endfunction

    // Execute one instruction on the shadow state and return the writeback it reports
    function automatic t_rsp compute_writeback(t_req r);
        logic [DATA_W-1:0] a_val;
        logic [DATA_W-1:0] b_val;
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  dest;
        t_rsp              wb;
        dest = r.target_reg;
        case (r.operation)
            OP_ADDI, OP_ADDIS: begin
                a_val = (r.source_a_reg == '0) ? '0 : read_shadow(r.source_a_reg);
                if (r.operation == OP_ADDI) begin
                    b_val = {{(DATA_W-IMM_W){r.immediate[IMM_W-1]}}, r.immediate};
                end else begin
                    b_val = {r.immediate, {(DATA_W-IMM_W){1'b0}}};
                end
                value = a_val + b_val;
                write_shadow(dest, value);
            end
            OP_ADD: begin
                a_val = read_shadow(r.source_a_reg);
                b_val = read_shadow(r.source_b_reg);
                value = a_val + b_val;
                write_shadow(dest, value);
                // signed overflow: like-signed operands, sum of the other sign
                if (r.record_overflow) begin
                    shadow_ov = (a_val[DATA_W-1] == b_val[DATA_W-1]) &&
                                (value[DATA_W-1] != a_val[DATA_W-1]);
                    if (shadow_ov) begin
                        shadow_so = 1'b1;
                    end
                end
                if (r.record_cr0) begin
                    if (value[DATA_W-1]) begin
                        shadow_cr0 = CR_NEG;
                    end else if (value != '0) begin
                        shadow_cr0 = CR_POS;
                    end else begin
                        shadow_cr0 = CR_ZERO;
                    end
                    if (shadow_so) begin
                        shadow_cr0 = shadow_cr0 | CR_SO;
                    end
                end
            end
            default: begin
                // ori reads rS from the D field and writes the A field
                value = read_shadow(r.target_reg) | {{(DATA_W-IMM_W){1'b0}}, r.immediate};
                dest  = r.source_a_reg;
                write_shadow(dest, value);
            end
        endcase
        wb.dest_reg         = dest;
        wb.written_value    = value;
        wb.cr0_field        = shadow_cr0;
        wb.overflow_flag    = shadow_ov;
        wb.summary_overflow = shadow_so;
        return wb;
    endfunction

    function automatic t_req make_request(t_op op, logic [IDX_W-1:0] d, logic [IDX_W-1:0] a,
                                          logic [IDX_W-1:0] b, logic [IMM_W-1:0] imm,
                                          logic oe, logic rc);
        t_req r;
        r.operation       = op;
        r.target_reg      = d;
        r.source_a_reg    = a;
        r.source_b_reg    = b;
        r.immediate       = imm;
        r.record_overflow = oe;
        r.record_cr0      = rc;
        return r;
    endfunction

    // bias towards a few registers so that results feed later requests
    function automatic logic [IDX_W-1:0] pick_reg();
        if ($urandom_range(0, 1) == 0) begin
            return IDX_W'($urandom_range(0, 7));
        end
        return IDX_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [IMM_W-1:0] pick_imm();
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0:       return 16'h0000;
                1:       return 16'h7FFF;
                2:       return 16'h8000;
                default: return 16'hFFFF;
            endcase
        end
        return IMM_W'($urandom());
    endfunction

    function automatic t_req random_request();
        int sel;
        t_op op;
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            op = OP_ADDI;
        end else if (sel < 40) begin
            op = OP_ADDIS;
        end else if (sel < 75) begin
            op = OP_ADD;
        end else begin
            op = OP_ORI;
        end
        return make_request(op, pick_reg(), pick_reg(), pick_reg(), pick_imm(),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // Offer one request, hold until accepted and record its writeback; with gaps, drop valid after each burst
    task automatic send_request(input t_req r, input bit with_gaps);
        int gap;
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge clk); while (!req_if.ready);
        writeback_q.push_back(compute_writeback(r));
        if (with_gaps) begin
            burst_left--;
            if (burst_left <= 0) begin
                gap = $urandom_range(1, 8);
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
        end
    endtask

    // Receiver: free flow, coin toss, mostly stalled and a periodic pattern in turn, or held off on request
    initial begin
        int tick;
        tick = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            tick++;
            if (hold_off_req) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else begin
                case ((tick / 50) % 4)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_if.ready <= ((tick % 3) != 0);
                endcase
            end
        end
    end

    function automatic void compare_field(string name, logic [DATA_W-1:0] want,
                                          logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each returned writeback with the oldest one predicted
    initial begin
        t_rsp want;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready) begin
                if (writeback_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual dest %0d value 0x%0h",
                             $time, rsp_if.data.dest_reg, rsp_if.data.written_value);
                    mismatch_count++;
                end else begin
                    want = writeback_q.pop_front();
                    compare_field("dest_reg", DATA_W'(want.dest_reg),
                                  DATA_W'(rsp_if.data.dest_reg));
                    compare_field("written_value", want.written_value,
                                  rsp_if.data.written_value);
                    compare_field("cr0_field", DATA_W'(want.cr0_field),
                                  DATA_W'(rsp_if.data.cr0_field));
                    compare_field("overflow_flag", DATA_W'(want.overflow_flag),
                                  DATA_W'(rsp_if.data.overflow_flag));
                    compare_field("summary_overflow", DATA_W'(want.summary_overflow),
                                  DATA_W'(rsp_if.data.summary_overflow));
                end
            end
        end
    end

    // Drop the run when neither channel moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    // Immediate extremes, every operation, ignored flags, both overflow directions
    task automatic test_directed_cases();
        send_request(make_request(OP_ADDI,  5'd1,  5'd0,  5'd0,  16'h7FFF, 1'b0, 1'b0), 1'b1);
        send_request(make_request(OP_ADDI,  5'd2,  5'd0,  5'd0,  16'h8000, 1'b0, 1'b0), 1'b1);
        send_request(make_request(OP_ADDIS, 5'd3,  5'd0,  5'd0,  16'h7FFF, 1'b0, 1'b0), 1'b1);
        send_request(make_request(OP_ORI,   5'd3,  5'd4,  5'd0,  16'hFFFF, 1'b0, 1'b0), 1'b1);
        send_request(make_request(OP_ADDIS, 5'd5,  5'd0,  5'd0,  16'h8000, 1'b0, 1'b0), 1'b1);
        send_request(make_request(OP_ADDI,  5'd6,  5'd0,  5'd0,  16'h0001, 1'b1, 1'b1), 1'b1);
        // positive overflow with both updates
        send_request(make_request(OP_ADD,   5'd7,  5'd4,  5'd6,  16'h0000, 1'b1, 1'b1), 1'b1);
        // overflow bit clears, summary stays
        send_request(make_request(OP_ADD,   5'd8,  5'd1,  5'd6,  16'h0000, 1'b1, 1'b0), 1'b1);
        // negative overflow to a zero sum
        send_request(make_request(OP_ADD,   5'd9,  5'd5,  5'd5,  16'h0000, 1'b1, 1'b1), 1'b1);
        send_request(make_request(OP_ADD,   5'd10, 5'd4,  5'd6,  16'h0000, 1'b0, 1'b1), 1'b1);
        send_request(make_request(OP_ORI,   5'd1,  5'd0,  5'd0,  16'h0000, 1'b1, 1'b1), 1'b1);
        // A of zero reads as zero for addi and addis only
        send_request(make_request(OP_ADDI,  5'd11, 5'd0,  5'd0,  16'h0005, 1'b1, 1'b1), 1'b1);
        send_request(make_request(OP_ADDIS, 5'd12, 5'd1,  5'd0,  16'hFFFF, 1'b0, 1'b1), 1'b1);
        send_request(make_request(OP_ADD,   5'd13, 5'd0,  5'd1,  16'h0000, 1'b0, 1'b1), 1'b1);
        send_request(make_request(OP_ADDI,  5'd31, 5'd31, 5'd0,  16'hFFFF, 1'b0, 1'b0), 1'b1);
        send_request(make_request(OP_ORI,   5'd31, 5'd31, 5'd31, 16'h0000, 1'b0, 1'b0), 1'b1);
        send_request(make_request(OP_ADD,   5'd14, 5'd2,  5'd2,  16'h0000, 1'b1, 1'b1), 1'b1);
        send_request(make_request(OP_ADDI,  5'd31, 5'd31, 5'd31, 16'hFFFF, 1'b1, 1'b1), 1'b1);
        send_request(make_request(OP_ADD,   5'd0,  5'd31, 5'd31, 16'hFFFF, 1'b0, 1'b1), 1'b1);
        send_request(make_request(OP_ADD,   5'd15, 5'd6,  5'd0,  16'h0000, 1'b1, 1'b1), 1'b1);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_request(random_request(), 1'b1);
    endtask

    // Each request reads the register written by the one before, back to back
    task automatic test_dependent_chain(input int count);
        t_req             r;
        logic [IDX_W-1:0] last_dest;
        last_dest = 5'd1;
        repeat (count) begin
            r = random_request();
            if (r.operation == OP_ORI) begin
                r.target_reg = last_dest;
                last_dest    = r.source_a_reg;
            end else begin
                r.source_a_reg = last_dest;
                if ($urandom_range(0, 1) == 0) begin
                    r.source_b_reg = last_dest;
                end
                last_dest = r.target_reg;
            end
            send_request(r, 1'b0);
        end
    endtask

    // Hold the receiver off while requests keep coming, so the input stalls
    task automatic test_receiver_hold_off(input int count);
        hold_off_req = 1'b1;
        repeat (count) send_request(random_request(), 1'b0);
    endtask

    // Build two operands with addis and ori, the first with its upper half near 0x7FFF or 0xFFFF, then add them
    task automatic test_overflow_sequences(input int count);
        logic [IDX_W-1:0] ra;
        logic [IDX_W-1:0] rb;
        repeat (count) begin
            ra = IDX_W'($urandom_range(1, 31));
            rb = IDX_W'($urandom_range(1, 31));
            send_request(make_request(OP_ADDIS, ra, 5'd0, 5'd0,
                                      16'h7FFF ^ IMM_W'($urandom_range(0, 3) << 15) ^
                                      IMM_W'($urandom_range(0, 15)), 1'b0, 1'b0), 1'b1);
            send_request(make_request(OP_ORI, ra, ra, 5'd0, pick_imm(), 1'b0, 1'b0), 1'b1);
            send_request(make_request(OP_ADDIS, rb, 5'd0, 5'd0, pick_imm(), 1'b0, 1'b0), 1'b1);
            send_request(make_request(OP_ORI, rb, rb, 5'd0, pick_imm(), 1'b0, 1'b0), 1'b1);
            send_request(make_request(OP_ADD, pick_reg(), ra, rb, pick_imm(),
                                      ($urandom_range(0, 3) != 0), ($urandom_range(0, 3) != 0)),
                         1'b1);
        end
    endtask

    initial begin
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        foreach (shadow_gpr[i]) shadow_gpr[i] = '0;
        shadow_cr0 = '0;
        shadow_ov  = 1'b0;
        shadow_so  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_mix(500);
        test_dependent_chain(300);
        test_receiver_hold_off(60);
        test_overflow_sequences(80);
        test_random_mix(500);

        // drain the pipeline, then allow for any stray result
        req_if.valid <= 1'b0;
        while (writeback_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ppcalu_pkg.sv
rtl/core/ppcalu_req_if.sv
rtl/core/ppcalu_rsp_if.sv
rtl/core/ppcalu_regfile.sv
rtl/core/ppcalu_exec.sv
rtl/core/ppc_integer_add_or_unit.sv
tb/sv/tb_ppc_integer_add_or_unit.sv
